// ----- src/b2da_pkg.sv -----
// Shared constants and control types of the binary to decimal ASCII unit.
package b2da_pkg;

  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned NUM_DIGITS_DEF = 20;
  localparam int unsigned CHAR_W         = 6;
  localparam int unsigned BCD_W          = 4;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [BCD_W-1:0]  BCD_FIVE   = 4'd5;
  localparam logic [BCD_W-1:0]  BCD_THREE  = 4'd3;

  typedef struct packed {
    logic load;
    logic conv;
    logic dig_shift;
    logic out_load;
    logic out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic top_zero;
  } dp_status_t;

endpackage

// ----- src/b2da_in_if.sv -----
// Request channel carrying one binary value.
interface b2da_in_if;
  logic                             valid;
  logic                             ready;
  logic [b2da_pkg::VALUE_W-1:0]     value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- src/b2da_out_if.sv -----
// Result channel carrying one ASCII digit and the end-of-run flag.
interface b2da_out_if;
  logic                             valid;
  logic                             ready;
  logic [b2da_pkg::CHAR_W-1:0]      digit_char;
  logic                             last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ----- src/b2da_datapath.sv -----
// Shift-and-add-3 BCD converter and digit output register.
module b2da_datapath #(
  parameter int unsigned VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
  parameter int unsigned NUM_DIGITS = b2da_pkg::NUM_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic [b2da_pkg::VALUE_W-1:0]  value_i,
  input  b2da_pkg::dp_cmd_t             cmd_i,
  output b2da_pkg::dp_status_t          status_o,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_o
);

  localparam int unsigned BCD_TOT_W = NUM_DIGITS * b2da_pkg::BCD_W;

  logic [VALUE_BITS-1:0]             bin_q, bin_d;
  logic [BCD_TOT_W-1:0]              bcd_q, bcd_d, bcd_adj;
  logic [b2da_pkg::BCD_W-1:0]        top_digit;
  logic [b2da_pkg::CHAR_W-1:0]       char_q, char_d;
  logic                              last_q, last_d;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*b2da_pkg::BCD_W +: b2da_pkg::BCD_W] >= b2da_pkg::BCD_FIVE) begin
        bcd_adj[i*b2da_pkg::BCD_W +: b2da_pkg::BCD_W] =
          bcd_q[i*b2da_pkg::BCD_W +: b2da_pkg::BCD_W] + b2da_pkg::BCD_THREE;
      end else begin
        bcd_adj[i*b2da_pkg::BCD_W +: b2da_pkg::BCD_W] =
          bcd_q[i*b2da_pkg::BCD_W +: b2da_pkg::BCD_W];
      end
    end
  end

  assign top_digit = bcd_q[BCD_TOT_W-1 -: b2da_pkg::BCD_W];

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.load) begin
      bin_d = value_i[VALUE_BITS-1:0];
      bcd_d = '0;
    end else if (cmd_i.conv) begin
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      bcd_d = {bcd_adj[BCD_TOT_W-2:0], bin_q[VALUE_BITS-1]};
    end else if (cmd_i.dig_shift) begin
      bcd_d = {bcd_q[BCD_TOT_W-b2da_pkg::BCD_W-1:0], {b2da_pkg::BCD_W{1'b0}}};
    end
    if (cmd_i.out_load) begin
      char_d = b2da_pkg::ASCII_ZERO
             + {{(b2da_pkg::CHAR_W-b2da_pkg::BCD_W){1'b0}}, top_digit};
      last_d = cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.top_zero = (top_digit == '0);
  assign digit_char_o      = char_q;
  assign last_o            = last_q;

endmodule

// ----- src/b2da_ctrl.sv -----
// Controller sequencing load, conversion and digit emission.
module b2da_ctrl #(
  parameter int unsigned VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
  parameter int unsigned NUM_DIGITS = b2da_pkg::NUM_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  b2da_pkg::dp_status_t  status_i,
  output b2da_pkg::dp_cmd_t     cmd_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             started_q, started_d;
  logic             slot_free, cnt_one;

  assign slot_free = !out_valid_q || out_ready_i;
  assign cnt_one   = (cnt_q == CNT_W'(1));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(VALUE_BITS);
          started_d  = 1'b0;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.conv = 1'b1;
        cnt_d      = cnt_q - CNT_W'(1);
        if (cnt_one) begin
          cnt_d   = CNT_W'(NUM_DIGITS);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.dig_shift = 1'b1;
          cnt_d           = cnt_q - CNT_W'(1);
          if (!status_i.top_zero || started_q || cnt_one) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_last = cnt_one;
            out_valid_d    = 1'b1;
            started_d      = 1'b1;
            if (cnt_one) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/binary_to_decimal_ascii_unit.sv -----
// Top level of the binary to decimal ASCII unit.
//
//   channel  | dir | payload                    | per request
//   in_i     | in  | value[63:0]                | one number
//   out_o    | out | digit_char[5:0], last      | 1 to NUM_DIGITS digits, MSD first
//
// A request is loaded, then runs VALUE_BITS shift-and-add-3 steps, then walks the
// BCD digits out MSD first, leading zeros dropped, each digit through the output
// register. Output stalls hold the digit walk. A new request is taken as soon as
// the last digit is in the output register.
// Reset clears the controller and the output valid flag.
module binary_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b2da_in_if.sink     in_i,
  b2da_out_if.source  out_o
);

  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  b2da_pkg::dp_cmd_t    cmd;
  b2da_pkg::dp_status_t status;

  b2da_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  b2da_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .value_i      (in_i.value),
    .cmd_i        (cmd),
    .status_o     (status),
    .digit_char_o (out_o.digit_char),
    .last_o       (out_o.last)
  );

endmodule

// ----- verif/tb_binary_to_decimal_ascii_unit.sv -----
// Self-checking testbench of the binary to decimal ASCII unit.
module tb_binary_to_decimal_ascii_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS = b2da_pkg::VALUE_BITS_DEF;
  localparam int unsigned MAX_DIGITS = b2da_pkg::NUM_DIGITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 1 + VALUE_BITS + MAX_DIGITS + 15;
  localparam int unsigned ITEMS_PER_PHASE = 68;
  localparam logic [b2da_pkg::VALUE_W-1:0] VALUE_MASK =
    (VALUE_BITS >= b2da_pkg::VALUE_W) ? {b2da_pkg::VALUE_W{1'b1}}
                                      : ((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] digit_char;
    logic                        last;
  } ascii_digit_t;

  class decimal_text_tracker;
    ascii_digit_t pending_digits[$];
    int unsigned  mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function void note_number(logic [b2da_pkg::VALUE_W-1:0] value);
      logic [b2da_pkg::BCD_W-1:0]   digs[MAX_DIGITS];
      logic [b2da_pkg::VALUE_W-1:0] rest;
      int unsigned                  n;
      ascii_digit_t                 d;
      rest = value & VALUE_MASK;
      n = 0;
      do begin
        digs[n] = b2da_pkg::BCD_W'(rest % 64'd10);
        rest = rest / 64'd10;
        n++;
      end while (rest != '0 && n < MAX_DIGITS);
      for (int k = 0; k < n; k++) begin
        d.digit_char = b2da_pkg::CHAR_W'(digs[n-1-k]) + b2da_pkg::ASCII_ZERO;
        d.last       = (k == n - 1);
        pending_digits.push_back(d);
      end
    endfunction

    function void check_digit(logic [b2da_pkg::CHAR_W-1:0] digit_char, logic last);
      ascii_digit_t want;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit: actual digit_char=%0d last=%0b",
                 $time, digit_char, last);
        mismatch_count++;
        return;
      end
      want = pending_digits.pop_front();
      if (digit_char !== want.digit_char) begin
        $display("%0t: digit_char mismatch: expected %0d actual %0d",
                 $time, want.digit_char, digit_char);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %0b actual %0b",
                 $time, want.last, last);
        mismatch_count++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_digits.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  b2da_in_if  in_if ();
  b2da_out_if out_if ();

  binary_to_decimal_ascii_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  decimal_text_tracker tracker;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      tracker.check_digit(out_if.digit_char, out_if.last);
    end
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_number(input logic [b2da_pkg::VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.note_number(value);
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [b2da_pkg::VALUE_W-1:0] random_number();
    logic [b2da_pkg::VALUE_W-1:0] raw;
    logic [b2da_pkg::VALUE_W-1:0] p10;
    int unsigned                  k;
    raw = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return raw;
      1: return raw >> $urandom_range(63);
      2: begin
        k = $urandom_range(19, 1);
        p10 = 64'd1;
        for (int i = 0; i < k; i++) p10 = p10 * 64'd10;
        return raw % p10;
      end
      default: begin
        k = $urandom_range(19);
        p10 = 64'd1;
        for (int i = 0; i < k; i++) p10 = p10 * 64'd10;
        return p10 + b2da_pkg::VALUE_W'($urandom_range(2)) - 64'd1;
      end
    endcase
  endfunction

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_number(random_number());
  endtask

  initial begin
    tracker        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_number(64'd0);
    send_number(64'd1);
    send_number(64'd9);
    send_number(64'd10);
    send_number(64'd99);
    send_number(64'd100);
    send_number(64'd1000000);
    send_number(64'd9999999999);
    send_number(64'd10000000000000000000);
    send_number(64'd9999999999999999999);
    send_number(64'd1000000000000000000);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'h7FFF_FFFF_FFFF_FFFF);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'hFFFF_FFFF_FFFF_FFFE);
    send_number(64'h5555_5555_5555_5555);
    send_number(64'hAAAA_AAAA_AAAA_AAAA);
    send_number(64'h0000_0000_FFFF_FFFF);
    send_number(64'h0000_0001_0000_0000);
    send_number(64'd255);
    hold_until_drained();

    run_phase(0, 0);
    run_phase(69, 0);
    hold_until_drained();
    run_phase(0, 69);
    run_phase(33, 33);

    in_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
